>>> rtl/core/ivo_pkg.sv
`timescale 1ns / 1ps

package ivo_pkg;

   localparam int TIME_W = 32;
   localparam int OVL_W = 9;
   localparam logic [OVL_W-1:0] OVERLAP_MAX = 9'd511;
   localparam int CAPACITY_DEF = 256;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;    // capture the request word and rewind the sweep
      logic sweep;   // walk the stored table, one entry per cycle
      logic commit;  // store the new entry unless the table was full, and load the response register
   } ivo_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic full;        // no free slot remains
      logic sweep_done;  // every stored entry has been read and any write-back is done
      logic rsp_free;    // the response register can take a new word
   } ivo_status_type;

endpackage

>>> rtl/core/ivo_ctrl.sv
`timescale 1ns / 1ps

module ivo_ctrl
   import ivo_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  ivo_status_type status,
   output ivo_cmd_type    cmd
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SWEEP  = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in   = state_ff;
      req_ready  = 1'b0;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               // A booking that finds the table full skips the sweep.
               state_in = status.full ? ST_FINISH : ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            cmd.sweep = 1'b1;
            if (status.sweep_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (status.rsp_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTHESIS
   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.sweep, cmd.commit}))
      else $error("controller issued more than one command");

   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> status.rsp_free)
      else $error("commit while the response register is occupied");

   a_load_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff != ST_IDLE)
      else $error("controller stayed idle after taking a request");
`endif

endmodule

>>> rtl/core/ivo_dpath.sv
`timescale 1ns / 1ps

module ivo_dpath
   import ivo_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [TIME_W-1:0] req_start_time,
   input  logic [TIME_W-1:0] req_end_time,
   input  ivo_cmd_type       cmd,
   output ivo_status_type    status,
   input  logic              rsp_ready,
   output logic              rsp_valid,
   output logic [OVL_W-1:0]  rsp_max_overlap,
   output logic              rsp_table_full
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int XW = (CW > OVL_W) ? CW : OVL_W;
   localparam int EW = 2 * TIME_W + CW;

   // Each entry holds start, end and the number of valid intervals that
   // cover its start point.
   logic [EW-1:0] mem_ff [CAPACITY];
   logic [EW-1:0] rd_data_ff;
   logic          rd_en;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [EW-1:0] wr_data;

   logic [TIME_W-1:0] s_ff, e_ff;
   logic              drop_ff;
   logic [CW-1:0]     count_ff, count_in;
   logic [OVL_W-1:0]  best_ff, best_in;
   logic [CW-1:0]     rd_idx_ff;
   logic              pend_ff;
   logic [AW-1:0]     pend_idx_ff;
   logic [CW-1:0]     new_cnt_ff, new_cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [OVL_W-1:0]  rsp_max_ff;
   logic              rsp_full_ff;

   logic [TIME_W-1:0] j_start, j_end;
   logic [CW-1:0]     j_cnt, j_cnt_inc;
   logic [XW-1:0]     j_wide, new_wide;
   logic [OVL_W-1:0]  j_sat, new_sat;
   logic              covered, j_valid, hits_new, new_valid;
   logic [OVL_W-1:0]  sweep_best;

   assign j_start   = rd_data_ff[EW-1 -: TIME_W];
   assign j_end     = rd_data_ff[CW+TIME_W-1 -: TIME_W];
   assign j_cnt     = rd_data_ff[CW-1:0];
   assign j_cnt_inc = j_cnt + CW'(1);

   assign covered   = (s_ff <= j_start) && (j_start < e_ff);
   assign j_valid   = j_start < j_end;
   assign hits_new  = (j_start <= s_ff) && (s_ff < j_end);
   assign new_valid = s_ff < e_ff;

   assign j_wide   = XW'(j_cnt_inc);
   assign j_sat    = (j_wide > XW'(OVERLAP_MAX)) ? OVERLAP_MAX : j_wide[OVL_W-1:0];
   assign new_wide = XW'(new_cnt_ff);
   assign new_sat  = (new_wide > XW'(OVERLAP_MAX)) ? OVERLAP_MAX : new_wide[OVL_W-1:0];

   assign rd_en = cmd.sweep && (rd_idx_ff < count_ff);

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = pend_idx_ff;
      wr_data = {j_start, j_end, j_cnt_inc};
      if (cmd.commit && !drop_ff) begin
         wr_en   = 1'b1;
         wr_addr = count_ff[AW-1:0];
         wr_data = {s_ff, e_ff, new_cnt_ff};
      end else if (pend_ff && covered) begin
         wr_en = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_idx_ff[AW-1:0]];
      end
   end

   always_comb begin
      sweep_best = best_ff;
      if (pend_ff && covered && j_valid && (j_sat > best_ff)) begin
         sweep_best = j_sat;
      end
   end

   always_comb begin
      best_in      = sweep_best;
      count_in     = count_ff;
      new_cnt_in   = new_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.load) begin
         // The new interval is counted as covering its own start point; the count is used only if it is valid.
         new_cnt_in = CW'(1);
      end else if (pend_ff && hits_new) begin
         new_cnt_in = new_cnt_ff + CW'(1);
      end
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
         if (!drop_ff) begin
            count_in = count_ff + CW'(1);
            if (new_valid && (new_sat > best_ff)) begin
               best_in = new_sat;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         best_ff      <= '0;
         pend_ff      <= 1'b0;
         rd_idx_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         best_ff      <= best_in;
         pend_ff      <= rd_en;
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.load) begin
            rd_idx_ff <= '0;
         end else if (rd_en) begin
            rd_idx_ff <= rd_idx_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      new_cnt_ff <= new_cnt_in;
      if (rd_en) begin
         pend_idx_ff <= rd_idx_ff[AW-1:0];
      end
      if (cmd.load) begin
         s_ff    <= req_start_time;
         e_ff    <= req_end_time;
         drop_ff <= status.full;
      end
      if (cmd.commit) begin
         rsp_max_ff  <= best_in;
         rsp_full_ff <= drop_ff;
      end
   end

   assign status.full       = count_ff == CW'(CAPACITY);
   assign status.sweep_done = !rd_en && !pend_ff;
   assign status.rsp_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_max_overlap = rsp_max_ff;
   assign rsp_table_full  = rsp_full_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("slot count exceeds capacity");

   a_best_monotonic: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> best_ff >= $past(best_ff))
      else $error("running maximum decreased");

   a_pend_in_range: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> CW'(pend_idx_ff) < count_ff)
      else $error("sweep read beyond the stored entries");

   a_drop_keeps_count: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && drop_ff) |=> count_ff == $past(count_ff))
      else $error("dropped booking changed the slot count");
`endif

endmodule

>>> rtl/core/interval_max_overlap_counter_core.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake               Word
// req       in         req_valid / req_ready   req_start_time, req_end_time
// rsp       out        rsp_valid / rsp_ready   rsp_max_overlap, rsp_table_full
//
// A stored booking sweeps every interval already stored before it loads its response word: the
// sweep reads one entry per cycle and, in the cycle after its read, writes back each entry
// whose start point the new interval covers, through a separate write port.
// A booking that finds the table full skips the sweep and loads its response in the finish state.
// Reset empties the table at once; no clearing pass is needed.
// A stalled response holds the next booking in its final state until rsp is taken.

module interval_max_overlap_counter_core
   import ivo_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [TIME_W-1:0] req_start_time,
   input  logic [TIME_W-1:0] req_end_time,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [OVL_W-1:0]  rsp_max_overlap,
   output logic              rsp_table_full
);

   ivo_cmd_type    cmd;
   ivo_status_type status;

   ivo_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   ivo_dpath #(
      .CAPACITY (CAPACITY)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .req_start_time  (req_start_time),
      .req_end_time    (req_end_time),
      .cmd             (cmd),
      .status          (status),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_max_overlap (rsp_max_overlap),
      .rsp_table_full  (rsp_table_full)
   );

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import ivo_pkg::*;

   typedef struct packed {
      logic [TIME_W-1:0] start_t;
      logic [TIME_W-1:0] stop_t;
   } booking_type;

   typedef struct packed {
      logic [OVL_W-1:0] overlap;
      logic             full;
   } answer_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [TIME_W-1:0] req_start_time = '0;
   logic [TIME_W-1:0] req_end_time = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [OVL_W-1:0]  rsp_max_overlap;
   logic              rsp_table_full;

   booking_type bookings[$];
   answer_type  answers_due[$];

   // Own copy of the booking table and the running peak.
   logic [TIME_W-1:0] held_start[CAPACITY_DEF];
   logic [TIME_W-1:0] held_stop[CAPACITY_DEF];
   int                held_count = 0;
   logic [OVL_W-1:0]  peak_overlap = '0;

   logic req_taken = 1'b0;
   logic rsp_taken = 1'b0;
   int   send_wait = 0;
   int   recv_wait = 0;
   int   sent_count = 0;
   int   rsp_seen = 0;
   int   full_seen = 0;
   int   error_count = 0;

   interval_max_overlap_counter_core u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_start_time  (req_start_time),
      .req_end_time    (req_end_time),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_max_overlap (rsp_max_overlap),
      .rsp_table_full  (rsp_table_full)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   // Every fourth stretch of 60 words runs without any idle cycles.
   function automatic int pick_wait(input int n);
      if ((n / 60) % 4 == 3) return 0;
      return $urandom_range(0, 18);
   endfunction

   function automatic int covered_by(input logic [TIME_W-1:0] point);
      int n;
      n = 0;
      for (int j = 0; j < held_count; j++)
         if (held_start[j] <= point && point < held_stop[j]) n++;
      return n;
   endfunction

   // Only points inside the new interval can gain coverage, so only the
   // stored start points in that range need a fresh count.
   function automatic void book_interval(input logic [TIME_W-1:0] s,
                                         input logic [TIME_W-1:0] e);
      answer_type ans;
      int         c;
      if (held_count >= CAPACITY_DEF) begin
         ans.full = 1'b1;
      end else begin
         ans.full = 1'b0;
         held_start[held_count] = s;
         held_stop[held_count] = e;
         held_count++;
         for (int i = 0; i < held_count; i++) begin
            if (held_start[i] < held_stop[i] && held_start[i] >= s && held_start[i] < e) begin
               c = covered_by(held_start[i]);
               if (c > OVERLAP_MAX) c = int'(OVERLAP_MAX);
               if (c > peak_overlap) peak_overlap = c[OVL_W-1:0];
            end
         end
      end
      ans.overlap = peak_overlap;
      answers_due.push_back(ans);
   endfunction

   always @(negedge clock) begin
      booking_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
         send_wait <= pick_wait(0);
      end else if (!req_valid || req_taken) begin
         if (send_wait > 0) begin
            req_valid <= 1'b0;
            send_wait <= send_wait - 1;
         end else if (bookings.size() > 0) begin
            nxt = bookings.pop_front();
            req_start_time <= nxt.start_t;
            req_end_time <= nxt.stop_t;
            req_valid <= 1'b1;
            sent_count <= sent_count + 1;
            send_wait <= pick_wait(sent_count + 1);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      int w;
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_wait <= pick_wait(0);
      end else if (rsp_taken) begin
         w = pick_wait(rsp_seen);
         recv_wait <= w;
         rsp_ready <= (w == 0);
      end else if (recv_wait > 0) begin
         recv_wait <= recv_wait - 1;
         rsp_ready <= (recv_wait == 1);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      answer_type due;
      req_taken <= !reset && req_valid && req_ready;
      rsp_taken <= !reset && rsp_valid && rsp_ready;
      if (!reset) begin
         // Check before booking so a same-edge response cannot match its own word.
         if (rsp_valid && rsp_ready) begin
            rsp_seen <= rsp_seen + 1;
            if (rsp_table_full === 1'b1) full_seen <= full_seen + 1;
            if (answers_due.size() == 0) begin
               $display("%0t: response with none pending: overlap=%0d full=%0b",
                        $time, rsp_max_overlap, rsp_table_full);
               error_count++;
            end else begin
               due = answers_due.pop_front();
               if (rsp_max_overlap !== due.overlap) begin
                  $display("%0t: max_overlap expected %0d, actual %0d",
                           $time, due.overlap, rsp_max_overlap);
                  error_count++;
               end
               if (rsp_table_full !== due.full) begin
                  $display("%0t: table_full expected %0b, actual %0b",
                           $time, due.full, rsp_table_full);
                  error_count++;
               end
            end
         end
         if (req_valid && req_ready) book_interval(req_start_time, req_end_time);
      end
   end

   initial begin
      #(4_000_000);
      $display("Verification failed");
      $finish;
   end

   initial begin
      logic [TIME_W-1:0] s, e, base;
      int                kind;
      int                tail;

      // Extremes, empty and reversed intervals, nesting and half-open touching.
      bookings.push_back('{32'h0000_0000, 32'hFFFF_FFFF});
      bookings.push_back('{32'hFFFF_FFFF, 32'h0000_0000});
      bookings.push_back('{32'h0000_0005, 32'h0000_0005});
      bookings.push_back('{32'h0000_0000, 32'h0000_0000});
      bookings.push_back('{32'hFFFF_FFFF, 32'hFFFF_FFFF});
      bookings.push_back('{32'hFFFF_FFFE, 32'hFFFF_FFFF});
      bookings.push_back('{32'h0000_0000, 32'h0000_0001});
      bookings.push_back('{32'h0000_000A, 32'h0000_0014});
      bookings.push_back('{32'h0000_000C, 32'h0000_0012});
      bookings.push_back('{32'h0000_000F, 32'h0000_0010});
      bookings.push_back('{32'h0000_0014, 32'h0000_001E});
      bookings.push_back('{32'h0000_0013, 32'h0000_0015});
      bookings.push_back('{32'h8000_0000, 32'h8000_0001});
      bookings.push_back('{32'h7FFF_FFFF, 32'h8000_0001});
      bookings.push_back('{32'hAAAA_AAAA, 32'h5555_5555});
      bookings.push_back('{32'h5555_5555, 32'hAAAA_AAAA});
      bookings.push_back('{32'h0000_000E, 32'h0000_000D});
      bookings.push_back('{32'h0000_000F, 32'h0000_0011});

      base = '0;
      for (int k = 0; k < 732; k++) begin
         if (k % 100 == 0) begin
            case ($urandom_range(0, 2))
               0: base = '0;
               1: base = 32'hFFFF_FF00;
               default: base = $urandom;
            endcase
         end
         kind = $urandom_range(0, 19);
         if (kind < 10) begin
            s = base + $urandom_range(0, 200);
            e = s + $urandom_range(1, 60);
         end else if (kind < 13) begin
            s = base + $urandom_range(0, 200);
            e = s - $urandom_range(0, 20);
         end else if (kind < 16) begin
            s = $urandom;
            e = $urandom;
         end else begin
            s = base + $urandom_range(0, 20);
            e = base + $urandom_range(150, 260);
         end
         bookings.push_back('{s, e});
      end

      while (bookings.size() > 0 || req_valid) @(posedge clock);
      while (answers_due.size() > 0) @(posedge clock);
      // Longest booking is one sweep of a full table followed by its commit.
      repeat (CAPACITY_DEF + 40) @(posedge clock);

      tail = held_count;
      $display("Sent %0d bookings, %0d responses, %0d stored, %0d turned away as full.",
               sent_count, rsp_seen, tail, full_seen);
      $display("Highest overlap reached: %0d.", peak_overlap);
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

>>> interval_max_overlap_counter_core.f
rtl/core/ivo_pkg.sv
rtl/core/ivo_ctrl.sv
rtl/core/ivo_dpath.sv
rtl/core/interval_max_overlap_counter_core.sv
tb/sv/tb_top.sv
